// ----- hdl/csc_pkg.sv -----
package csc_pkg;

    // port field widths
    localparam int RING_W   = 6;
    localparam int SECTOR_W = 7;
    localparam int HEIGHT_W = 16;
    localparam int SIM_W    = 17;
    localparam int SHIFT_W  = 7;
    localparam int CFG_W    = 8;
    localparam int RCFG_W   = 7;

    // width of the exact cosine quotient and of its square root
    localparam int QUO_W  = 33;
    localparam int ROOT_W = 17;
    localparam int SQR_W  = 21;

    // register indexes
    typedef enum logic {
        CFG_RINGS   = 1'b0,
        CFG_SECTORS = 1'b1
    } t_cfg_index;

    // sequencer states
    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_RUN   = 10'b00_0000_0100,
        ST_DRAIN = 10'b00_0000_1000,
        ST_SETUP = 10'b00_0001_0000,
        ST_MULN  = 10'b00_0010_0000,
        ST_MULD  = 10'b00_0100_0000,
        ST_DIV   = 10'b00_1000_0000,
        ST_SQRT  = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } t_state;

    // kind of sweep over the grids
    typedef enum logic [1:0] {
        PASS_NQ  = 2'd0,
        PASS_NC  = 2'd1,
        PASS_DOT = 2'd2
    } t_pass;

endpackage

// ----- hdl/circular_shift_cosine_match.sv -----
// Circular-shift cosine match. Cells of a query and a candidate height grid are
// loaded one beat each; an ordinary beat is taken while the block is idle and
// leaves it ready for the next. A beat with last set starts the match: one shared
// multiplier and accumulator sweeps the R x S grid once for |q|^2, once for
// |c|^2 and once for each of the S circular shifts, one cell pair a cycle (the
// shift sweeps are skipped when either grid is all zero), followed by bit-serial
// multiplication, division and square root for the exact Q1.16 cosine.
// After each result, and after reset, both cell memories are cleared one entry
// a cycle, all MAX_RINGS * MAX_SECTORS entries (8192 at the defaults), during
// which no beat is accepted; configuration writes are taken at any time.
module circular_shift_cosine_match #(
    parameter int MAX_RINGS   = 64,
    parameter int MAX_SECTORS = 128,
    parameter int VALUE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [csc_pkg::CFG_W-1:0]     i_cfg_data,
    // cell input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [csc_pkg::RING_W-1:0]    i_ring,
    input  logic [csc_pkg::SECTOR_W-1:0]  i_sector,
    input  logic [csc_pkg::HEIGHT_W-1:0]  i_query_value,
    input  logic [csc_pkg::HEIGHT_W-1:0]  i_candidate_value,
    input  logic                          i_last,
    // match result
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [csc_pkg::SIM_W-1:0]     o_similarity,
    output logic [csc_pkg::SHIFT_W-1:0]   o_peak_shift,
    output logic                          o_degenerate
);
    import csc_pkg::*;

    localparam int CELLS = MAX_RINGS * MAX_SECTORS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int SW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int VB    = VALUE_BITS;
    localparam int ACC_W = 2 * VB + AW;
    localparam int PW    = 2 * ACC_W;
    localparam int IT_W  = $clog2(ACC_W + QUO_W + 1);

    // configuration registers
    logic [RCFG_W-1:0] r_cfg_rings;
    logic [CFG_W-1:0]  r_cfg_sectors;

    // control
    t_state          r_state;
    t_pass           r_pass;
    logic [AW-1:0]   r_clr;
    logic [SW-1:0]   r_s, r_cs, r_k, r_slast;
    logic [RW-1:0]   r_r, r_rlast;
    logic [AW-1:0]   r_base;
    logic            r_v1, r_v2;
    logic [IT_W-1:0] r_it;

    // datapath
    logic [VB-1:0]     r_qd, r_cd;
    logic [2*VB-1:0]   r_prod;
    logic [ACC_W-1:0]  r_acc, r_nq, r_nc, r_best;
    logic [SW-1:0]     r_best_k;
    logic              r_deg;
    logic [PW-1:0]     r_mp, r_num, r_den, r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [QUO_W:0]    r_sqsrc;
    logic [SQR_W-1:0]  r_sqrem;
    logic [ROOT_W-1:0] r_root;

    // result register
    logic                r_out_valid;
    logic [SIM_W-1:0]    r_similarity;
    logic [SHIFT_W-1:0]  r_peak_shift;
    logic                r_degenerate;

    // cell memories
    logic [VB-1:0] r_qmem [CELLS];
    logic [VB-1:0] r_cmem [CELLS];

    logic          in_acc;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [VB-1:0] mem_wq, mem_wc;
    logic [AW-1:0] rd_q, rd_c;
    logic [VB-1:0] op_a, op_b;
    logic [9:0]    rn_clamp, sn_clamp;

    logic [ACC_W-1:0] mcand;
    logic [ACC_W:0]   msum;
    logic [PW-1:0]    mp_next;
    logic [PW:0]      dshift;
    logic             dge;
    logic [QUO_W-1:0] quo_next;
    logic [SQR_W-1:0] srem, strial;
    logic             sge;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // cell address of an input beat
    assign in_range = (10'(i_ring) < 10'(MAX_RINGS)) && (11'(i_sector) < 11'(MAX_SECTORS));
    assign in_addr  = AW'(AW'(i_ring) * AW'(MAX_SECTORS)) + AW'(i_sector);

    // memory write: clearing sweep or loaded cell
    always_comb begin
        mem_we = 1'b0;
        mem_wa = in_addr;
        mem_wq = VB'(i_query_value);
        mem_wc = VB'(i_candidate_value);
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wq = '0;
            mem_wc = '0;
        end else if (in_acc && in_range) begin
            mem_we = 1'b1;
        end
    end

    assign rd_q = r_base + AW'(r_s);
    assign rd_c = r_base + AW'(r_cs);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_qmem[mem_wa] <= mem_wq;
            r_cmem[mem_wa] <= mem_wc;
        end
        r_qd <= r_qmem[rd_q];
        r_cd <= r_cmem[rd_c];
    end

    // shared multiplier operands
    always_comb begin
        op_a = r_qd;
        op_b = r_cd;
        case (r_pass)
            PASS_NQ: op_b = r_qd;
            PASS_NC: op_a = r_cd;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // clamped ring and sector counts
    always_comb begin
        rn_clamp = 10'(r_cfg_rings);
        if (rn_clamp == 10'd0) rn_clamp = 10'd1;
        if (rn_clamp > 10'(MAX_RINGS)) rn_clamp = 10'(MAX_RINGS);
        sn_clamp = 10'(r_cfg_sectors);
        if (sn_clamp == 10'd0) sn_clamp = 10'd1;
        if (sn_clamp > 10'(MAX_SECTORS)) sn_clamp = 10'(MAX_SECTORS);
    end

    // shift-add multiplier step
    always_comb begin
        mcand   = (r_state == ST_MULN) ? r_best : r_nq;
        msum    = {1'b0, r_mp[PW-1:ACC_W]} + (r_mp[0] ? {1'b0, mcand} : '0);
        mp_next = {msum, r_mp[ACC_W-1:1]};
    end

    // restoring division step
    always_comb begin
        dshift   = {r_rem, (r_it == '0) ? r_num[0] : 1'b0};
        dge      = dshift >= {1'b0, r_den};
        quo_next = {r_quo[QUO_W-2:0], dge};
    end

    // square root step
    always_comb begin
        srem   = {r_sqrem[SQR_W-3:0], r_sqsrc[QUO_W:QUO_W-1]};
        strial = SQR_W'({r_root, 2'b01});
        sge    = srem >= strial;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rings   <= RCFG_W'(20);
            r_cfg_sectors <= CFG_W'(60);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RINGS:   r_cfg_rings   <= i_cfg_data[RCFG_W-1:0];
                CFG_SECTORS: r_cfg_sectors <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pass      <= PASS_NQ;
            r_clr       <= '0;
            r_s         <= '0;
            r_cs        <= '0;
            r_k         <= '0;
            r_r         <= '0;
            r_base      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_it        <= '0;
            r_deg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_RUN);
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_out_valid && i_out_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc && i_last) begin
                        r_slast <= SW'(sn_clamp - 10'd1);
                        r_rlast <= RW'(rn_clamp - 10'd1);
                        r_pass  <= PASS_NQ;
                        r_deg   <= 1'b0;
                        r_k     <= '0;
                        r_s     <= '0;
                        r_cs    <= '0;
                        r_r     <= '0;
                        r_base  <= '0;
                        r_acc   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // one cell pair issued each cycle
                    if (r_s == r_slast) begin
                        r_s  <= '0;
                        r_cs <= r_k;
                        if (r_r == r_rlast) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_r    <= r_r + RW'(1);
                            r_base <= r_base + AW'(MAX_SECTORS);
                        end
                    end else begin
                        r_s  <= r_s + SW'(1);
                        r_cs <= (r_cs == r_slast) ? '0 : r_cs + SW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_s    <= '0;
                        r_r    <= '0;
                        r_base <= '0;
                        r_acc  <= '0;
                        case (r_pass)
                            PASS_NQ: begin
                                r_nq    <= r_acc;
                                r_pass  <= PASS_NC;
                                r_cs    <= '0;
                                r_state <= ST_RUN;
                            end
                            PASS_NC: begin
                                r_nc <= r_acc;
                                if (r_nq == '0 || r_acc == '0) begin
                                    r_deg   <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_pass  <= PASS_DOT;
                                    r_k     <= '0;
                                    r_cs    <= '0;
                                    r_state <= ST_RUN;
                                end
                            end
                            default: begin
                                // keep the first shift with the largest dot
                                if (r_k == '0 || r_acc > r_best) begin
                                    r_best   <= r_acc;
                                    r_best_k <= r_k;
                                end
                                if (r_k == r_slast) begin
                                    r_state <= ST_SETUP;
                                end else begin
                                    r_k     <= r_k + SW'(1);
                                    r_cs    <= r_k + SW'(1);
                                    r_state <= ST_RUN;
                                end
                            end
                        endcase
                    end
                end
                ST_SETUP: begin
                    r_mp    <= {{ACC_W{1'b0}}, r_best};
                    r_it    <= '0;
                    r_state <= ST_MULN;
                end
                ST_MULN: begin
                    // best dot squared
                    if (r_it == IT_W'(ACC_W - 1)) begin
                        r_num   <= mp_next;
                        r_mp    <= {{ACC_W{1'b0}}, r_nc};
                        r_it    <= '0;
                        r_state <= ST_MULD;
                    end else begin
                        r_mp <= mp_next;
                        r_it <= r_it + IT_W'(1);
                    end
                end
                ST_MULD: begin
                    // product of the two squared norms
                    if (r_it == IT_W'(ACC_W - 1)) begin
                        r_den   <= mp_next;
                        r_rem   <= r_num >> 1;
                        r_quo   <= '0;
                        r_it    <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_mp <= mp_next;
                        r_it <= r_it + IT_W'(1);
                    end
                end
                ST_DIV: begin
                    // floor(dot^2 * 2^32 / (nq * nc)), one bit a cycle
                    r_rem <= dge ? PW'(dshift - {1'b0, r_den}) : PW'(dshift);
                    r_quo <= quo_next;
                    if (r_it == IT_W'(QUO_W - 1)) begin
                        r_sqsrc <= {1'b0, quo_next};
                        r_sqrem <= '0;
                        r_root  <= '0;
                        r_it    <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_it <= r_it + IT_W'(1);
                    end
                end
                ST_SQRT: begin
                    // integer square root, one result bit a cycle
                    r_sqrem <= sge ? srem - strial : srem;
                    r_root  <= {r_root[ROOT_W-2:0], sge};
                    r_sqsrc <= r_sqsrc << 2;
                    r_it    <= r_it + IT_W'(1);
                    if (r_it == IT_W'(ROOT_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_similarity <= r_deg ? '0 : r_root;
                        r_peak_shift <= r_deg ? '0 : SHIFT_W'(r_best_k);
                        r_degenerate <= r_deg;
                        r_clr        <= '0;
                        r_state      <= ST_CLEAR;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_similarity = r_similarity;
    assign o_peak_shift = r_peak_shift;
    assign o_degenerate = r_degenerate;

    // a last beat always starts a match
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> !o_in_ready)
        else $error("block still ready after a last beat");

    // a degenerate result carries no similarity and no shift
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_degenerate) |-> (r_similarity == '0 && r_peak_shift == '0))
        else $error("degenerate result with non-zero fields");

    // cosine never exceeds one
    a_sim_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_similarity <= SIM_W'(65536)))
        else $error("similarity above full scale");

endmodule
